>>> hdl/rfcp_pkg.sv
// Shared types and constants of the radio FIFO chunk parser.
package rfcp_pkg;

   // Depth of the queue between the parsing front end and the result back end.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RSSI_OFFSET  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_DATA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_TIMER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_RSSI    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_FREQ    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_ANTENNA = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_RSSI    = 2'd1;
   localparam logic [1:0] KIND_FREQ    = 2'd2;

   // Header byte layout.
   localparam logic [2:0] LEN_EXTENDED = 3'h7;

   // Configuration values that the parser uses.
   typedef struct packed {
      logic signed [7:0] rssi_offset;
      logic [4:0]        code_data;
      logic [4:0]        code_rssi;
      logic [4:0]        code_freq;
   } cfg_type;

   // One classified result waiting for the back end.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic        last_byte;
      logic [19:0] freq_offset;
   } q_entry_type;

   // Queue fill status.
   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } q_status_type;

endpackage

>>> hdl/radio_fifo_chunk_parser.sv
// An accepted byte's result is written into the queue, then into the output register that drives rsp_valid.
// Throughput: one byte per cycle; the front end takes a byte every cycle the queue is not full.
// A stalled result is held in the output register while the two-entry queue keeps filling.
// Reset is synchronous and active high: it returns the parser to expect a chunk header,
// empties the queue and the output register, and loads the register reset values.
// Top level of the radio FIFO chunk parser with its configuration registers.
module radio_fifo_chunk_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_fifo_byte,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_payload_byte,
   output logic [7:0]                     rsp_byte_index,
   output logic                           rsp_last_byte,
   output logic signed [8:0]              rsp_rssi,
   output logic signed [19:0]             rsp_freq_offset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rfcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data
);
   import rfcp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         req_accept;
   logic         push_valid;
   q_entry_type  push_entry;
   logic         head_valid;
   q_entry_type  head_entry;
   logic         pop;
   q_status_type q_status;

   // Configuration writes. Timer and antenna codes only ever mean a skip,
   // which is what any unmatched command gets, so they need no storage.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RSSI_OFFSET:  cfg_in.rssi_offset = $signed(csr_data);
            CSR_CODE_DATA:    cfg_in.code_data   = csr_data[4:0];
            CSR_CODE_RSSI:    cfg_in.code_rssi   = csr_data[4:0];
            CSR_CODE_FREQ:    cfg_in.code_freq   = csr_data[4:0];
            CSR_CODE_TIMER,
            CSR_CODE_ANTENNA: cfg_in = cfg_ff;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rssi_offset <= 8'sd0;
         cfg_ff.code_data   <= 5'd1;
         cfg_ff.code_rssi   <= 5'd17;
         cfg_ff.code_freq   <= 5'd19;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input handshake: stall only while the queue is full.
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   rfcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .fifo_byte  (req_fifo_byte),
      .restart    (req_restart),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   rfcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .status     (q_status)
   );

   rfcp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .rssi_offset      (cfg_ff.rssi_offset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_rssi         (rsp_rssi),
      .rsp_freq_offset  (rsp_freq_offset)
   );

   // A queued result reaches an empty output register in the next cycle.
   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      (q_status.count != '0 && !rsp_valid) |=> rsp_valid)
      else $error("queued result did not reach the output register");

   // The queue never holds more than its depth.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QDEPTH))
      else $error("queue count beyond its depth");

   // A full queue admits no new result.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push_valid)
      else $error("result pushed into a full queue");

   // A payload transaction carries no RSSI or frequency bits.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_PAYLOAD)
         |-> (rsp_rssi == 9'sd0 && rsp_freq_offset == 20'sd0))
      else $error("payload transaction with foreign fields set");

endmodule

>>> hdl/rfcp_front.sv
// Front end: accepts FIFO bytes, tracks the chunk state and classifies results.
module rfcp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           fifo_byte,
   input  logic                 restart,
   input  rfcp_pkg::cfg_type    cfg,
   output logic                 push_valid,
   output rfcp_pkg::q_entry_type push_entry
);
   import rfcp_pkg::*;

   typedef enum logic [6:0] {
      PH_HEADER     = 7'b0000001,
      PH_EXTLEN     = 7'b0000010,
      PH_DATA_FLAGS = 7'b0000100,
      PH_DATA       = 7'b0001000,
      PH_RSSI       = 7'b0010000,
      PH_FREQ       = 7'b0100000,
      PH_SKIP       = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_eff;
   logic [4:0]  pending_ff, pending_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [7:0]  position_ff, position_in;
   logic [19:0] acc_ff, acc_in;
   logic        do_chunk;
   logic [4:0]  chunk_cmd;
   logic [7:0]  chunk_len;
   logic [7:0]  remaining_dec;
   logic [19:0] acc_next;

   // A restart forces the byte to be taken as a header.
   assign phase_eff     = restart ? PH_HEADER : phase_ff;
   assign remaining_dec = remaining_ff - 8'd1;
   assign chunk_cmd     = (phase_eff == PH_EXTLEN) ? pending_ff : fifo_byte[4:0];
   assign chunk_len     = (phase_eff == PH_EXTLEN) ? fifo_byte : {5'd0, fifo_byte[7:5]};
   assign acc_next      = (remaining_ff == 8'd3) ? {16'd0, fifo_byte[3:0]}
                                                 : {acc_ff[11:0], fifo_byte};

   // Next-state and result classification for one accepted byte.
   always_comb begin
      phase_in     = phase_ff;
      pending_in   = pending_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      acc_in       = acc_ff;
      do_chunk     = 1'b0;
      push_valid   = 1'b0;
      push_entry   = '0;
      if (accept) begin
         unique case (phase_eff)
            PH_EXTLEN: begin
               do_chunk = 1'b1;
            end
            PH_DATA_FLAGS: begin
               if (remaining_ff == 8'd0) begin
                  phase_in = PH_HEADER;
               end else begin
                  position_in = 8'd0;
                  phase_in    = PH_DATA;
               end
            end
            PH_DATA: begin
               push_valid            = 1'b1;
               push_entry.kind       = KIND_PAYLOAD;
               push_entry.data_byte  = fifo_byte;
               push_entry.byte_index = position_ff;
               push_entry.last_byte  = (remaining_ff <= 8'd1);
               position_in           = position_ff + 8'd1;
               remaining_in          = remaining_dec;
               if (remaining_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_RSSI: begin
               push_valid           = 1'b1;
               push_entry.kind      = KIND_RSSI;
               push_entry.data_byte = fifo_byte;
               phase_in             = PH_HEADER;
            end
            PH_FREQ: begin
               acc_in       = acc_next;
               remaining_in = remaining_dec;
               if (remaining_dec == 8'd0) begin
                  push_valid             = 1'b1;
                  push_entry.kind        = KIND_FREQ;
                  push_entry.freq_offset = acc_next;
                  phase_in               = PH_HEADER;
               end
            end
            PH_SKIP: begin
               remaining_in = remaining_dec;
               if (remaining_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               // Header byte, also taken for any phase code that means nothing.
               pending_in = fifo_byte[4:0];
               if (fifo_byte[7:5] == LEN_EXTENDED) begin
                  phase_in = PH_EXTLEN;
               end else begin
                  do_chunk = 1'b1;
               end
            end
         endcase

         // Start a chunk once its command and length are known. Timer, antenna
         // and unknown commands fall through to the skip, or to the header when empty.
         if (do_chunk) begin
            priority if (chunk_cmd == cfg.code_data) begin
               if (chunk_len == 8'd0) begin
                  phase_in = PH_HEADER;
               end else begin
                  remaining_in = chunk_len - 8'd1;
                  phase_in     = PH_DATA_FLAGS;
               end
            end else if (chunk_cmd == cfg.code_freq && chunk_len == 8'd3) begin
               remaining_in = 8'd3;
               acc_in       = 20'd0;
               phase_in     = PH_FREQ;
            end else if (chunk_cmd == cfg.code_rssi && chunk_len == 8'd1) begin
               phase_in = PH_RSSI;
            end else if (chunk_len == 8'd0) begin
               phase_in = PH_HEADER;
            end else begin
               remaining_in = chunk_len;
               phase_in     = PH_SKIP;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         pending_ff   <= 5'd0;
         remaining_ff <= 8'd0;
         position_ff  <= 8'd0;
         acc_ff       <= 20'd0;
      end else begin
         phase_ff     <= phase_in;
         pending_ff   <= pending_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         acc_ff       <= acc_in;
      end
   end

endmodule

>>> hdl/rfcp_queue.sv
// Short register queue between the front end and the back end.
module rfcp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rfcp_pkg::q_entry_type  push_entry,
   input  logic                   pop,
   output logic                   head_valid,
   output rfcp_pkg::q_entry_type  head_entry,
   output rfcp_pkg::q_status_type status
);
   import rfcp_pkg::*;

   q_entry_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and count update; a push never arrives while full.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid   = (count_ff != '0);
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == QCNT_W'(QDEPTH));

endmodule

>>> hdl/rfcp_back.sv
// Back end: formats queued results and holds them in the output register.
module rfcp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [7:0]     rssi_offset,
   input  logic                  head_valid,
   input  rfcp_pkg::q_entry_type head_entry,
   output logic                  pop,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_payload_byte,
   output logic [7:0]            rsp_byte_index,
   output logic                  rsp_last_byte,
   output logic signed [8:0]     rsp_rssi,
   output logic signed [19:0]    rsp_freq_offset
);
   import rfcp_pkg::*;

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [7:0]        payload_ff, index_ff;
   logic              last_ff;
   logic signed [8:0] rssi_ff, rssi_in;
   logic [19:0]       freq_ff;
   logic              is_payload, is_rssi, is_freq;

   // Take the queue head when the output register is empty or being emptied.
   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);

   assign is_payload = (head_entry.kind == KIND_PAYLOAD);
   assign is_rssi    = (head_entry.kind == KIND_RSSI);
   assign is_freq    = (head_entry.kind == KIND_FREQ);

   // Signed RSSI byte minus the signed offset, in nine bits.
   assign rssi_in = $signed({head_entry.data_byte[7], head_entry.data_byte})
                  - $signed({rssi_offset[7], rssi_offset});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result fields; those not of the result's kind are zero.
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff    <= head_entry.kind;
         payload_ff <= is_payload ? head_entry.data_byte : 8'd0;
         index_ff   <= is_payload ? head_entry.byte_index : 8'd0;
         last_ff    <= is_payload && head_entry.last_byte;
         rssi_ff    <= is_rssi ? rssi_in : 9'sd0;
         freq_ff    <= is_freq ? head_entry.freq_offset : 20'd0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_byte_index   = index_ff;
   assign rsp_last_byte    = last_ff;
   assign rsp_rssi         = rssi_ff;
   assign rsp_freq_offset  = $signed(freq_ff);

endmodule

>>> verif/radio_fifo_chunk_parser_checker.sv
`timescale 1ns / 100ps
// Checker of the radio FIFO chunk parser: predicts results from accepted bytes and compares them.
module radio_fifo_chunk_parser_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_fifo_byte,
   input  logic                           req_restart,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_kind,
   input  logic [7:0]                     rsp_payload_byte,
   input  logic [7:0]                     rsp_byte_index,
   input  logic                           rsp_last_byte,
   input  logic signed [8:0]              rsp_rssi,
   input  logic signed [19:0]             rsp_freq_offset,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rfcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_data,
   output int                             error_count,
   output int                             pending_count
);
   import rfcp_pkg::*;

   // Where the parser stands within the byte stream.
   typedef enum logic [6:0] {
      WAIT_HEADER  = 7'b0000001,
      WAIT_EXT_LEN = 7'b0000010,
      WAIT_FLAGS   = 7'b0000100,
      IN_PAYLOAD   = 7'b0001000,
      IN_RSSI      = 7'b0010000,
      IN_FREQ      = 7'b0100000,
      IN_SKIP      = 7'b1000000
   } parse_state_type;

   // One result as it should appear on the result channel.
   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         payload_byte;
      logic [7:0]         byte_index;
      logic               last_byte;
      logic signed [8:0]  rssi;
      logic signed [19:0] freq_offset;
   } chunk_result_type;

   // Register copies. Timer and antenna codes only lead to a skip, which any
   // unmatched command gets anyway.
   logic [7:0] rssi_offset;
   logic [4:0] code_data;
   logic [4:0] code_rssi;
   logic [4:0] code_freq;

   // Parser state copy.
   parse_state_type state;
   logic [4:0]      command;
   logic [7:0]      bytes_left;
   logic [7:0]      position;
   logic [19:0]     freq_acc;

   chunk_result_type expected_results[$];
   chunk_result_type seen;
   chunk_result_type want;
   int               failures;

   // Text form of one result for the mismatch report.
   function automatic string show(input chunk_result_type r);
      return $sformatf("kind=%0d byte=%h idx=%0d last=%0b rssi=%0d freq=%0d",
                       r.kind, r.payload_byte, r.byte_index, r.last_byte,
                       r.rssi, r.freq_offset);
   endfunction

   // Decide how the body of a chunk is handled once its length is known.
   task automatic open_chunk(input logic [7:0] len);
      if (command == code_data) begin
         if (len == 8'd0) begin
            state = WAIT_HEADER;
         end else begin
            bytes_left = len - 8'd1;
            state = WAIT_FLAGS;
         end
      end else if (command == code_freq && len == 8'd3) begin
         bytes_left = 8'd3;
         freq_acc = '0;
         state = IN_FREQ;
      end else if (command == code_rssi && len == 8'd1) begin
         state = IN_RSSI;
      end else if (len == 8'd0) begin
         state = WAIT_HEADER;
      end else begin
         bytes_left = len;
         state = IN_SKIP;
      end
   endtask

   // Advance the parser by one FIFO byte and queue the result it produces, if any.
   task automatic parse_fifo_byte(input logic [7:0] b, input logic restart);
      chunk_result_type r;
      parse_state_type  now;
      r = '0;
      now = restart ? WAIT_HEADER : state;
      unique case (now)
         WAIT_EXT_LEN: begin
            open_chunk(b);
         end
         WAIT_FLAGS: begin
            // The flags byte is dropped; a chunk of only flags ends here.
            if (bytes_left == 8'd0) begin
               state = WAIT_HEADER;
            end else begin
               position = 8'd0;
               state = IN_PAYLOAD;
            end
         end
         IN_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.byte_index = position;
            r.last_byte = (bytes_left <= 8'd1);
            position = position + 8'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
               state = WAIT_HEADER;
            end
            expected_results.push_back(r);
         end
         IN_RSSI: begin
            r.kind = KIND_RSSI;
            r.rssi = $signed({b[7], b}) - $signed({rssi_offset[7], rssi_offset});
            state = WAIT_HEADER;
            expected_results.push_back(r);
         end
         IN_FREQ: begin
            // Only the low nibble of the first byte carries offset bits.
            if (bytes_left == 8'd3) begin
               freq_acc = {16'd0, b[3:0]};
            end else begin
               freq_acc = {freq_acc[11:0], b};
            end
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
               r.kind = KIND_FREQ;
               r.freq_offset = freq_acc;
               state = WAIT_HEADER;
               expected_results.push_back(r);
            end
         end
         IN_SKIP: begin
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'd0) begin
               state = WAIT_HEADER;
            end
         end
         default: begin
            command = b[4:0];
            if (b[7:5] == LEN_EXTENDED) begin
               state = WAIT_EXT_LEN;
            end else begin
               open_chunk({5'd0, b[7:5]});
            end
         end
      endcase
   endtask

   // Follow register writes, predict from input bytes and compare results.
   always @(posedge clock) begin
      if (reset) begin
         rssi_offset = 8'd0;
         code_data = 5'd1;
         code_rssi = 5'd17;
         code_freq = 5'd19;
         state = WAIT_HEADER;
         command = '0;
         bytes_left = '0;
         position = '0;
         freq_acc = '0;
         failures = 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RSSI_OFFSET: rssi_offset = csr_data;
               CSR_CODE_DATA:   code_data = csr_data[4:0];
               CSR_CODE_RSSI:   code_rssi = csr_data[4:0];
               CSR_CODE_FREQ:   code_freq = csr_data[4:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            parse_fifo_byte(req_fifo_byte, req_restart);
         end

         if (rsp_valid && !rsp_stall) begin
            seen.kind = rsp_kind;
            seen.payload_byte = rsp_payload_byte;
            seen.byte_index = rsp_byte_index;
            seen.last_byte = rsp_last_byte;
            seen.rssi = rsp_rssi;
            seen.freq_offset = rsp_freq_offset;
            if (expected_results.size() == 0) begin
               if (failures < 10) begin
                  $display("%0t: unexpected result %s", $time, show(seen));
               end
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (seen.kind !== want.kind || seen.payload_byte !== want.payload_byte ||
                   seen.byte_index !== want.byte_index || seen.last_byte !== want.last_byte ||
                   seen.rssi !== want.rssi || seen.freq_offset !== want.freq_offset) begin
                  if (failures < 10) begin
                     $display("%0t: mismatch expected %s", $time, show(want));
                     $display("%0t:          actual   %s", $time, show(seen));
                  end
                  failures++;
               end
            end
         end
      end
      pending_count = expected_results.size();
      error_count = failures;
   end

endmodule

>>> verif/radio_fifo_chunk_parser_test.sv
`timescale 1ns / 100ps
// Testbench top of the radio FIFO chunk parser: clock, reset, stimulus and verdict.
module radio_fifo_chunk_parser_test;
   import rfcp_pkg::*;

   // Indexes past the register list; writes to them must have no effect.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_fifo_byte;
   logic                 req_restart;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_kind;
   logic [7:0]           rsp_payload_byte;
   logic [7:0]           rsp_byte_index;
   logic                 rsp_last_byte;
   logic signed [8:0]    rsp_rssi;
   logic signed [19:0]   rsp_freq_offset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [7:0]           csr_data;

   int error_count;
   int pending_count;
   int items_sent;
   bit gaps_on = 1'b1;
   bit hold_go = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   // Command codes currently loaded, used to build well-formed chunks.
   logic [4:0] data_code = 5'd1;
   logic [4:0] timer_code = 5'd16;
   logic [4:0] rssi_code = 5'd17;
   logic [4:0] freq_code = 5'd19;
   logic [4:0] antenna_code = 5'd21;

   radio_fifo_chunk_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_fifo_byte    (req_fifo_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_rssi         (rsp_rssi),
      .rsp_freq_offset  (rsp_freq_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   radio_fifo_chunk_parser_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_fifo_byte    (req_fifo_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_rssi         (rsp_rssi),
      .rsp_freq_offset  (rsp_freq_offset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result receiver: random stalls, plus one long hold-off when requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= gaps_on && ($urandom_range(0, 99) < 33);
         end
      end
   end

   // Offer one FIFO byte and wait for the transaction; called and returns at a falling edge.
   task automatic offer_fifo_byte(input logic [7:0] b, input logic restart);
      while (gaps_on && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_fifo_byte <= b;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // One register write transaction; returns with valid low.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop offering bytes and wait until every expected result is out and the pipeline is empty.
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Reprogram all registers while the parser is idle.
   task automatic load_codes(input logic [7:0] offset, input logic [4:0] data,
                             input logic [4:0] timer, input logic [4:0] rssi,
                             input logic [4:0] freq, input logic [4:0] antenna);
      wait_for_quiet();
      write_register(CSR_RSSI_OFFSET, offset);
      write_register(CSR_CODE_DATA, {3'($urandom_range(0, 7)), data});
      write_register(CSR_CODE_TIMER, {3'($urandom_range(0, 7)), timer});
      write_register(CSR_CODE_RSSI, {3'($urandom_range(0, 7)), rssi});
      write_register(CSR_CODE_FREQ, {3'($urandom_range(0, 7)), freq});
      write_register(CSR_CODE_ANTENNA, {3'($urandom_range(0, 7)), antenna});
      data_code = data;
      timer_code = timer;
      rssi_code = rssi;
      freq_code = freq;
      antenna_code = antenna;
   endtask

   // One chunk, mostly well formed, with random content and the odd restart breaking it.
   task automatic offer_random_chunk();
      int         pick;
      int         len;
      logic [4:0] cmd;
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         cmd = data_code;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 9);
      end else if (pick < 11) begin
         cmd = rssi_code;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 1;
      end else if (pick < 14) begin
         cmd = freq_code;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 3;
      end else if (pick < 16) begin
         cmd = $urandom_range(0, 1) ? timer_code : antenna_code;
         len = $urandom_range(0, 8);
      end else if (pick < 18) begin
         cmd = 5'($urandom_range(0, 31));
         len = $urandom_range(0, 12);
      end else begin
         // Stray byte, parsed as whatever the current state makes of it.
         offer_fifo_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         return;
      end

      // Lengths of seven and up need the extended form; short ones use it at times too.
      if (len >= 7 || $urandom_range(0, 7) == 0) begin
         offer_fifo_byte({LEN_EXTENDED, cmd}, 1'($urandom_range(0, 1)));
         offer_fifo_byte(len[7:0], $urandom_range(0, 49) == 0);
      end else begin
         offer_fifo_byte({len[2:0], cmd}, 1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < len; i++) begin
         offer_fifo_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
      end
   endtask

   // Random chunks until the given number of further bytes has been taken.
   task automatic run_random(input int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) offer_random_chunk();
   endtask

   // Main stimulus.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_fifo_byte = 8'd0;
      req_restart = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = 8'd0;
      items_sent = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes with the reset register values.
      // Data chunk of three: flags, then payload at both byte extremes.
      offer_fifo_byte(8'h61, 1'b1);
      offer_fifo_byte(8'hFF, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'hFF, 1'b0);
      // Signal strength at the negative extreme.
      offer_fifo_byte(8'h31, 1'b0);
      offer_fifo_byte(8'h80, 1'b0);
      // Frequency offsets at the negative and positive extremes.
      offer_fifo_byte(8'h73, 1'b0);
      offer_fifo_byte(8'hF8, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'h73, 1'b0);
      offer_fifo_byte(8'h07, 1'b0);
      offer_fifo_byte(8'hFF, 1'b0);
      offer_fifo_byte(8'hFF, 1'b0);
      // Data chunks of length zero and one give no result.
      offer_fifo_byte(8'h01, 1'b0);
      offer_fifo_byte(8'h21, 1'b0);
      offer_fifo_byte(8'h5A, 1'b0);
      // Signal strength and frequency chunks of the wrong length are skipped.
      offer_fifo_byte(8'h51, 1'b0);
      offer_fifo_byte(8'h7F, 1'b0);
      offer_fifo_byte(8'h80, 1'b0);
      offer_fifo_byte(8'h33, 1'b0);
      offer_fifo_byte(8'h13, 1'b0);
      // Timer chunk and an unknown empty chunk are skipped.
      offer_fifo_byte(8'h50, 1'b0);
      offer_fifo_byte(8'h31, 1'b0);
      offer_fifo_byte(8'h55, 1'b0);
      offer_fifo_byte(8'h1F, 1'b0);
      // Extended length of zero, then of two.
      offer_fifo_byte(8'hE1, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'hE1, 1'b0);
      offer_fifo_byte(8'h02, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'hAA, 1'b0);
      // Restart in the middle of a data chunk turns the byte into a header.
      offer_fifo_byte(8'h81, 1'b0);
      offer_fifo_byte(8'h00, 1'b0);
      offer_fifo_byte(8'h11, 1'b0);
      offer_fifo_byte(8'h31, 1'b1);
      offer_fifo_byte(8'h7F, 1'b0);

      // Offset at its negative end, data code at the bottom, other codes near the top.
      load_codes(8'h80, 5'd0, 5'd31, 5'd31, 5'd30, 5'd29);
      write_register(CSR_SPARE_LO, 8'($urandom_range(0, 255)));
      write_register(CSR_SPARE_HI, 8'($urandom_range(0, 255)));
      run_random(70);

      // Offset at its positive end, data code on top, others low; a long receiver hold-off first.
      load_codes(8'h7F, 5'd31, 5'd0, 5'd0, 5'd1, 5'd2);
      gaps_on = 1'b0;
      hold_go = 1'b1;
      offer_fifo_byte({LEN_EXTENDED, data_code}, 1'b0);
      offer_fifo_byte(8'd60, 1'b0);
      for (int i = 0; i < 60; i++) offer_fifo_byte(8'($urandom_range(0, 255)), 1'b0);
      gaps_on = 1'b1;
      run_random(70);

      // All codes equal, and no idling on either side.
      load_codes(8'h01, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5);
      gaps_on = 1'b0;
      run_random(70);
      gaps_on = 1'b1;

      // Timer, signal strength and frequency share a code.
      load_codes(8'hFF, 5'd2, 5'd9, 5'd9, 5'd9, 5'd3);
      run_random(70);

      // Back to the reset values.
      load_codes(8'h00, 5'd1, 5'd16, 5'd17, 5'd19, 5'd21);
      run_random(70);

      // Random register values.
      load_codes(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      run_random(70);

      // Drain and report.
      wait_for_quiet();
      repeat (4) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
